FILE: rtl/lppl_pkg.sv
// Package for the light pen position latch: payload types, item kinds, port codes, flags.
package lppl_pkg;

    localparam int unsigned CNT_W = 12;
    localparam logic [CNT_W-1:0] CNT_MASK = 12'hfff;

    localparam logic [2:0] KIND_PIXEL = 3'd0;
    localparam logic [2:0] KIND_HSYNC = 3'd1;
    localparam logic [2:0] KIND_VSYNC = 3'd2;
    localparam logic [2:0] KIND_LIGHT = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    localparam logic [2:0] PORT_STATUS   = 3'd0;
    localparam logic [2:0] PORT_HIGH     = 3'd1;
    localparam logic [2:0] PORT_POS_LO   = 3'd2;
    localparam logic [2:0] PORT_LINE_LO  = 3'd3;
    localparam logic [2:0] PORT_CLR_STB  = 3'd4;
    localparam logic [2:0] PORT_MAN_STB  = 3'd5;
    localparam logic [2:0] PORT_IRQ_OFF  = 3'd6;
    localparam logic [2:0] PORT_IRQ_ACK  = 3'd7;

    localparam logic [7:0] FRAME_FLAG  = 8'h01;
    localparam logic [7:0] STROBE_FLAG = 8'h08;

    localparam logic [6:0] THRESHOLD_RESET = 7'd12;

    typedef struct packed {
        logic [2:0]       kind;
        logic [2:0]       address;
        logic [1:0]       buttons;
        logic             pen_present;
        logic             on_pen_line;
        logic [7:0]       brightness;
        logic [CNT_W-1:0] pen_position;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_line;
    } t_out;

endpackage

FILE: rtl/lppl_core.sv
// Counters, latches, status and interrupt state, updated once per transfer.
module lppl_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_wdata,
    input  logic               i_fire,
    input  lppl_pkg::t_in      i_item,
    output lppl_pkg::t_out     o_result
);

    logic [6:0]                 r_thr;
    logic [lppl_pkg::CNT_W-1:0] r_line, n_line;
    logic [lppl_pkg::CNT_W-1:0] r_pix, n_pix;
    logic [lppl_pkg::CNT_W-1:0] r_line_lat, n_line_lat;
    logic [lppl_pkg::CNT_W-1:0] r_pos_lat, n_pos_lat;
    logic [7:0]                 r_status, n_status;
    logic                       r_irq_en, n_irq_en;
    logic                       r_irq, n_irq;
    logic [7:0]                 data;
    logic                       hit;

    assign hit = i_item.pen_present && i_item.on_pen_line
                 && (i_item.brightness >= {1'b0, r_thr});

    always_comb begin
        n_line     = r_line;
        n_pix      = r_pix;
        n_line_lat = r_line_lat;
        n_pos_lat  = r_pos_lat;
        n_status   = r_status;
        n_irq_en   = r_irq_en;
        n_irq      = r_irq;
        data       = 8'h00;
        unique case (i_item.kind)
            lppl_pkg::KIND_PIXEL: n_pix = (r_pix + 12'd1) & lppl_pkg::CNT_MASK;
            lppl_pkg::KIND_HSYNC: begin
                n_line = (r_line + 12'd1) & lppl_pkg::CNT_MASK;
                n_pix  = '0;
            end
            lppl_pkg::KIND_VSYNC: begin
                n_line = '0;
                if ((r_status & lppl_pkg::FRAME_FLAG) == 8'h00) begin
                    n_status = r_status | lppl_pkg::FRAME_FLAG;
                    if (r_irq_en) n_irq = 1'b1;
                end
            end
            lppl_pkg::KIND_LIGHT: begin
                if (hit) begin
                    n_pix      = i_item.pen_position;
                    n_pos_lat  = i_item.pen_position;
                    n_line_lat = r_line;
                    n_status   = r_status | lppl_pkg::STROBE_FLAG;
                    if (r_irq_en) n_irq = 1'b1;
                end
            end
            lppl_pkg::KIND_READ: begin
                unique case (i_item.address)
                    lppl_pkg::PORT_STATUS:
                        data = ~(r_status | {5'b0, i_item.buttons[0], 2'b0})
                               | {5'b0, i_item.buttons[1], 2'b0};
                    lppl_pkg::PORT_HIGH:    data = {r_line_lat[11:8], r_pos_lat[11:8]};
                    lppl_pkg::PORT_POS_LO:  data = r_pos_lat[7:0];
                    lppl_pkg::PORT_LINE_LO: data = r_line_lat[7:0];
                    lppl_pkg::PORT_CLR_STB: n_status = r_status & ~lppl_pkg::STROBE_FLAG;
                    lppl_pkg::PORT_MAN_STB: begin
                        if ((r_status & lppl_pkg::STROBE_FLAG) == 8'h00) begin
                            n_pos_lat  = r_pix;
                            n_line_lat = r_line;
                            n_status   = r_status | lppl_pkg::STROBE_FLAG;
                            if (r_irq_en) n_irq = 1'b1;
                        end
                    end
                    lppl_pkg::PORT_IRQ_OFF: n_irq_en = 1'b0;
                    default: begin
                        n_irq_en = 1'b1;
                        n_status = r_status & ~lppl_pkg::FRAME_FLAG;
                        n_irq    = 1'b0;
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign o_result.read_data = data;
    assign o_result.irq_line  = n_irq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= lppl_pkg::THRESHOLD_RESET;
            r_line     <= '0;
            r_pix      <= '0;
            r_line_lat <= '0;
            r_pos_lat  <= '0;
            r_status   <= '0;
            r_irq_en   <= 1'b0;
            r_irq      <= 1'b0;
        end else begin
            if (i_cfg_we) r_thr <= i_cfg_wdata;
            if (i_fire) begin
                r_line     <= n_line;
                r_pix      <= n_pix;
                r_line_lat <= n_line_lat;
                r_pos_lat  <= n_pos_lat;
                r_status   <= n_status;
                r_irq_en   <= n_irq_en;
                r_irq      <= n_irq;
            end
        end
    end

    // Only the frame and strobe flags can ever be set.
    a_status_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status & ~(lppl_pkg::FRAME_FLAG | lppl_pkg::STROBE_FLAG)) == 8'h00)
        else $error("status holds a bit other than frame or strobe");

    // Interrupt level stays put while idle.
    a_irq_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_irq))
        else $error("interrupt level moved without a transfer");

    // A raised level needs interrupts enabled when it rose.
    a_irq_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !r_irq && n_irq) |-> r_irq_en)
        else $error("interrupt raised while disabled");

endmodule

FILE: rtl/lppl_outbuf.sv
// Result register with a skid stage so input transfers continue while a result waits.
module lppl_outbuf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lppl_pkg::t_out i_data,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_stall,
    output lppl_pkg::t_out o_data
);

    logic           r_out_valid, r_skid_valid;
    lppl_pkg::t_out r_out_data, r_skid_data;
    logic           take;

    assign take    = r_out_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) r_out_data <= r_skid_data;
        end else if (i_push) begin
            if (!r_out_valid || take) r_out_data <= i_data;
            else r_skid_data <= i_data;
        end
    end

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_skid_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && take) |=> (r_out_valid && r_out_data == $past(r_skid_data)))
        else $error("skid entry not advanced to output");

    a_push_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !r_skid_valid && !r_out_valid) |=>
        (r_out_valid && !r_skid_valid && r_out_data == $past(i_data)))
        else $error("transfer into empty buffer lost");

endmodule

FILE: rtl/lightpen_position_latch_ports_unit.sv
// Top level of the light pen position latch with its eight read ports.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one item per
//   transfer: a pixel tick, hsync, vsync, pen light event or bus read.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly
//   one result per item: the read byte (zero for non-read kinds) and the
//   interrupt level after the item.
//   Threshold register: write i_cfg_wdata with i_cfg_we high, while idle.
// Throughput: one item per cycle while the skid stage is free; all state is
//   updated in the transfer cycle by one pass of short logic, and the result
//   lands in the output register, or in the skid stage while that is held.
// Stall: a two-entry output buffer (result register plus skid stage) keeps
//   input transfers going while the receiver stalls; once the skid stage
//   is occupied, o_in_stall rises until the receiver takes data.
//   o_in_stall comes straight from a register.
// Reset: synchronous, active low; counters, latches, status, interrupt
//   enable and level clear, threshold returns to 12, output buffer empties.
module lightpen_position_latch_ports_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [6:0]     i_cfg_wdata,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  lppl_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output lppl_pkg::t_out o_out_data
);

    logic           fire;
    logic           full;
    lppl_pkg::t_out result;

    // Accept whenever the skid stage is free.
    assign o_in_stall = full;
    assign fire       = i_in_valid && !full;

    // Advance all state on the transfer and form the result.
    lppl_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_item      (i_in_data),
        .o_result    (result)
    );

    // Hold results until the receiver takes them.
    lppl_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (result),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

    // After a transfer, the output always shows a valid result next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("transfer produced no result");

    // Stall on the input only while a result is held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    // Buffer fills only if the receiver stalled.
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && o_out_valid && i_out_stall) |=> o_in_stall)
        else $error("skid stage not filled on stall");

endmodule

FILE: verif/lightpen_position_latch_ports_unit_tb.sv
// Self-checking testbench for the light pen position latch with its eight read ports.
module lightpen_position_latch_ports_unit_tb;

    // Clock period is 12; the watchdog limit is far above the longest legal gap
    // (receiver hold-off, threshold change, sender idles).
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned HOLD_CYCLES   = 60;
    localparam int unsigned PHASE_ITEMS   = 225;
    localparam int unsigned HSYNC_BURST   = 40;
    localparam int unsigned REPORT_LIMIT  = 10;

    // Scoreboard: tracks the pen latch state, predicts one reply per transfer
    // and checks replies in order.
    class lightpen_scoreboard;
        lppl_pkg::t_out expected_replies[$];
        logic [6:0]  threshold;
        logic [11:0] line_cnt;
        logic [11:0] pixel_cnt;
        logic [11:0] line_lat;
        logic [11:0] pos_lat;
        logic [7:0]  status;
        logic        irq_en;
        logic        irq_lvl;
        int unsigned mismatches;
        int unsigned checked;

        function new();
            threshold  = lppl_pkg::THRESHOLD_RESET;
            line_cnt   = '0;
            pixel_cnt  = '0;
            line_lat   = '0;
            pos_lat    = '0;
            status     = '0;
            irq_en     = 1'b0;
            irq_lvl    = 1'b0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_threshold(logic [6:0] value);
            threshold = value;
        endfunction

        // Advance the tracked state by one accepted item and queue its reply.
        function void note_item(lppl_pkg::t_in item);
            lppl_pkg::t_out reply;
            reply = '0;
            case (item.kind)
                lppl_pkg::KIND_PIXEL: pixel_cnt = pixel_cnt + 12'd1;
                lppl_pkg::KIND_HSYNC: begin
                    line_cnt  = line_cnt + 12'd1;
                    pixel_cnt = '0;
                end
                lppl_pkg::KIND_VSYNC: begin
                    line_cnt = '0;
                    if ((status & lppl_pkg::FRAME_FLAG) == 8'h00) begin
                        status = status | lppl_pkg::FRAME_FLAG;
                        if (irq_en) irq_lvl = 1'b1;
                    end
                end
                lppl_pkg::KIND_LIGHT: begin
                    if (item.pen_present && item.on_pen_line &&
                        item.brightness >= {1'b0, threshold}) begin
                        pixel_cnt = item.pen_position;
                        pos_lat   = item.pen_position;
                        line_lat  = line_cnt;
                        status    = status | lppl_pkg::STROBE_FLAG;
                        if (irq_en) irq_lvl = 1'b1;
                    end
                end
                lppl_pkg::KIND_READ: begin
                    case (item.address)
                        lppl_pkg::PORT_STATUS: reply.read_data =
                            ~(status | {5'b0, item.buttons[0], 2'b0}) |
                            {5'b0, item.buttons[1], 2'b0};
                        lppl_pkg::PORT_HIGH:
                            reply.read_data = {line_lat[11:8], pos_lat[11:8]};
                        lppl_pkg::PORT_POS_LO:  reply.read_data = pos_lat[7:0];
                        lppl_pkg::PORT_LINE_LO: reply.read_data = line_lat[7:0];
                        lppl_pkg::PORT_CLR_STB: status = status & ~lppl_pkg::STROBE_FLAG;
                        lppl_pkg::PORT_MAN_STB: begin
                            if ((status & lppl_pkg::STROBE_FLAG) == 8'h00) begin
                                pos_lat  = pixel_cnt;
                                line_lat = line_cnt;
                                status   = status | lppl_pkg::STROBE_FLAG;
                                if (irq_en) irq_lvl = 1'b1;
                            end
                        end
                        lppl_pkg::PORT_IRQ_OFF: irq_en = 1'b0;
                        lppl_pkg::PORT_IRQ_ACK: begin
                            irq_en  = 1'b1;
                            status  = status & ~lppl_pkg::FRAME_FLAG;
                            irq_lvl = 1'b0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            reply.irq_line = irq_lvl;
            expected_replies.push_back(reply);
        endfunction

        function void check_result(lppl_pkg::t_out got);
            lppl_pkg::t_out want;
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected reply: read_data=%02h irq_line=%0b",
                             got.read_data, got.irq_line);
                return;
            end
            want = expected_replies.pop_front();
            checked++;
            if (got.read_data !== want.read_data || got.irq_line !== want.irq_line) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"reply %0d mismatch: read_data exp %02h got %02h,",
                              " irq_line exp %0b got %0b"},
                             checked, want.read_data, got.read_data,
                             want.irq_line, got.irq_line);
            end
        endfunction
    endclass

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_cfg_we    = 1'b0;
    logic [6:0]     i_cfg_wdata = '0;
    logic           i_in_valid  = 1'b0;
    logic           o_in_stall;
    lppl_pkg::t_in  i_in_data   = '0;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    lppl_pkg::t_out o_out_data;

    lightpen_scoreboard board;

    int unsigned sent_items   = 0;
    int unsigned phases_run   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned hold_left    = 0;
    logic        hold_request = 1'b0;
    logic        quiet        = 1'b0;

    lightpen_position_latch_ports_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // Receiver: check every reply transfer, stall at random about 6% of the
    // time, drop stalls entirely during the quiet stretch, and on request hold
    // off for a long run of cycles so the input side backs up.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(o_out_data);
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_request) begin
            hold_request <= 1'b0;
            i_out_stall  <= 1'b1;
            hold_left    <= HOLD_CYCLES;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < 6);
        end
    end

    // Watchdog: count cycles with no transfer on either side; a stuck block
    // ends the run here.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic lppl_pkg::t_in make_item(logic [2:0] kind, logic [2:0] address,
                                                logic [1:0] buttons, logic present,
                                                logic online, logic [7:0] bright,
                                                logic [11:0] pos);
        lppl_pkg::t_in item;
        item.kind         = kind;
        item.address      = address;
        item.buttons      = buttons;
        item.pen_present  = present;
        item.on_pen_line  = online;
        item.brightness   = bright;
        item.pen_position = pos;
        return item;
    endfunction

    // Offer one item and hold it until the transfer; then, now and then, drop
    // valid and idle the sender. Otherwise valid is left high on return so the
    // next item follows back to back.
    task automatic send_item(lppl_pkg::t_in item);
        i_in_data  <= item;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_item(item);
        sent_items++;
        if (!quiet && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Drop valid, wait for every reply to land, then write the threshold.
    task automatic change_threshold(logic [6:0] value);
        i_in_valid <= 1'b0;
        while (board.expected_replies.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_threshold(value);
        phases_run++;
    endtask

    initial begin
        logic [6:0]    phase_thr[5];
        lppl_pkg::t_in item;
        int unsigned   pick;
        int unsigned   counted;

        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset threshold: status inversion with buttons,
        // frame flag and interrupt, latch at exactly the threshold, the three
        // failing light conditions, pixel wrap, every port, disabled interrupt,
        // unused kinds.
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_STATUS, 2'd0, 1'b0, 1'b0,
                            8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_STATUS, 2'd3, 1'b1, 1'b1,
                            8'd255, 12'hfff));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_IRQ_ACK, 2'd0, 1'b0, 1'b0,
                            8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_VSYNC, 3'd0, 2'd0, 1'b0, 1'b0, 8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_VSYNC, 3'd0, 2'd0, 1'b0, 1'b0, 8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_STATUS, 2'd1, 1'b0, 1'b0,
                            8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_STATUS, 2'd2, 1'b0, 1'b0,
                            8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_IRQ_ACK, 2'd0, 1'b0, 1'b0,
                            8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_LIGHT, 3'd0, 2'd0, 1'b1, 1'b1, 8'd12, 12'hfff));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_HIGH, 2'd0, 1'b0, 1'b0,
                            8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_POS_LO, 2'd0, 1'b0, 1'b0,
                            8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_LINE_LO, 2'd0, 1'b0, 1'b0,
                            8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_PIXEL, 3'd7, 2'd3, 1'b1, 1'b1, 8'd140, 12'd0));
        send_item(make_item(lppl_pkg::KIND_LIGHT, 3'd0, 2'd0, 1'b1, 1'b1, 8'd11, 12'h123));
        send_item(make_item(lppl_pkg::KIND_LIGHT, 3'd0, 2'd0, 1'b0, 1'b1, 8'd140, 12'h456));
        send_item(make_item(lppl_pkg::KIND_LIGHT, 3'd0, 2'd0, 1'b1, 1'b0, 8'd255, 12'h789));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_MAN_STB, 2'd0, 1'b0, 1'b0,
                            8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_CLR_STB, 2'd0, 1'b0, 1'b0,
                            8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_HSYNC, 3'd0, 2'd0, 1'b0, 1'b0, 8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_PIXEL, 3'd0, 2'd0, 1'b0, 1'b0, 8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_IRQ_ACK, 2'd0, 1'b0, 1'b0,
                            8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_IRQ_OFF, 2'd0, 1'b0, 1'b0,
                            8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_MAN_STB, 2'd0, 1'b0, 1'b0,
                            8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_VSYNC, 3'd0, 2'd0, 1'b0, 1'b0, 8'd0, 12'd0));
        send_item(make_item(3'd5, 3'd5, 2'd1, 1'b1, 1'b1, 8'd100, 12'h0f0));
        send_item(make_item(3'd6, 3'd6, 2'd2, 1'b0, 1'b1, 8'd50, 12'h00f));
        send_item(make_item(3'd7, 3'd7, 2'd3, 1'b1, 1'b0, 8'd200, 12'hf00));

        // Advance the line counter with a burst of hsyncs, then latch and read it back.
        for (int unsigned n = 0; n < HSYNC_BURST; n++)
            send_item(make_item(lppl_pkg::KIND_HSYNC, 3'($urandom_range(7)), 2'd0, 1'b0,
                                1'b0, 8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_CLR_STB, 2'd0, 1'b0, 1'b0,
                            8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_MAN_STB, 2'd0, 1'b0, 1'b0,
                            8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_LINE_LO, 2'd0, 1'b0, 1'b0,
                            8'd0, 12'd0));
        send_item(make_item(lppl_pkg::KIND_READ, lppl_pkg::PORT_HIGH, 2'd0, 1'b0, 1'b0,
                            8'd0, 12'd0));

        // Random phases over several thresholds, the extremes among them.
        phase_thr[0] = 7'd0;
        phase_thr[1] = 7'd100;
        phase_thr[2] = 7'd127;
        phase_thr[3] = 7'($urandom_range(1, 99));
        phase_thr[4] = lppl_pkg::THRESHOLD_RESET;
        for (int unsigned ph = 0; ph < 5; ph++) begin
            change_threshold(phase_thr[ph]);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                // Request the long receiver hold-off once, mid phase.
                if (ph == 0 && counted == 100) hold_request = 1'b1;
                // Hold a long stretch with no idling on either side.
                quiet = (ph == 1 && counted < 200);
                pick = $urandom_range(99);
                item.kind = (pick < 34) ? lppl_pkg::KIND_PIXEL :
                            (pick < 44) ? lppl_pkg::KIND_HSYNC :
                            (pick < 48) ? lppl_pkg::KIND_VSYNC :
                            (pick < 66) ? lppl_pkg::KIND_LIGHT :
                            (pick < 96) ? lppl_pkg::KIND_READ  : 3'($urandom_range(5, 7));
                item.address      = 3'($urandom_range(7));
                item.buttons      = 2'($urandom_range(3));
                item.pen_present  = ($urandom_range(99) < 85);
                item.on_pen_line  = ($urandom_range(99) < 85);
                item.brightness   = ($urandom_range(99) < 10) ? 8'($urandom_range(255))
                                                              : 8'($urandom_range(140));
                item.pen_position = 12'($urandom_range(4095));
                send_item(item);
                if (item.kind <= lppl_pkg::KIND_READ) counted++;
            end
            quiet = 1'b0;
        end

        // Drain: wait for every reply, then wait a little longer for any strays.
        i_in_valid <= 1'b0;
        while (board.expected_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Sent %0d items (directed, hsync burst, %0d threshold phases); %0d checked.",
                 sent_items, phases_run, board.checked);
        $display("Mismatches or stray replies: %0d", board.mismatches);
        if (board.mismatches == 0 && board.expected_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
